// ===== src/otq_pkg.sv =====
// ----------------------------------------------------------------------------
// otq_pkg: shared types and codes for the ordered timer expiry queue
// Action and result codes, the queued command word and the back-end FSM state.
// ----------------------------------------------------------------------------
`default_nettype none
package otq_pkg;
    localparam int unsigned ID_W   = 4;
    localparam int unsigned TIME_W = 64;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_STAT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        action_t             action;
        logic [ID_W-1:0]     timer_id;
        logic [TIME_W-1:0]   tval;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

// ===== src/otq_if.sv =====
// ----------------------------------------------------------------------------
// otq_in_if / otq_out_if: valid/ready channels of the timer queue
// One input word carries a command, one output word carries a result.
// ----------------------------------------------------------------------------
`default_nettype none
interface otq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [63:0] expiry_ns;
    logic [63:0] now_ns;
    modport source (output valid, action, timer_id, expiry_ns, now_ns, input ready);
    modport sink   (input valid, action, timer_id, expiry_ns, now_ns, output ready);
endinterface

interface otq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic       is_active;
    logic       last;
    modport source (output valid, kind, slot_id, is_active, last, input ready);
    modport sink   (input valid, kind, slot_id, is_active, last, output ready);
endinterface
`default_nettype wire

// ===== src/otq_front.sv =====
// ----------------------------------------------------------------------------
// otq_front: command intake and queue
// Accept input words, keep the operand the action needs, and queue them.
// ----------------------------------------------------------------------------
`default_nettype none
module otq_front (
    input  wire               clk,
    input  wire               rst_n,
    otq_in_if.sink            in_ch,
    output otq_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  wire               cmd_pop
);
    import otq_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_cmd.action   = action_t'(in_ch.action);
        in_cmd.timer_id = in_ch.timer_id;
        // tick uses now, everything else uses expiry
        in_cmd.tval = (action_t'(in_ch.action) == ACT_TICK) ? in_ch.now_ns : in_ch.expiry_ns;
    end

    assign cmd       = fifo_reg[rd_ptr_reg];
    assign cmd_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end
endmodule
`default_nettype wire

// ===== src/otq_back.sv =====
// ----------------------------------------------------------------------------
// otq_back: timer slot store and expiry sequencer
// Execute commands on the slots; on tick, emit due slots oldest-expiry first.
// ----------------------------------------------------------------------------
`default_nettype none
module otq_back #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  otq_pkg::cmd_t     cmd,
    input  wire               cmd_valid,
    output logic              cmd_pop,
    otq_out_if.source         out_ch
);
    import otq_pkg::*;

    localparam int unsigned AS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int unsigned SW = (AS > 1) ? $clog2(AS) : 1;

    typedef struct packed {
        logic              have;
        logic [TIME_W-1:0] val;
    } cand_t;

    logic [TIME_W-1:0] exp_reg [AS];
    logic [AS-1:0]     armed_reg;
    logic [AS-1:0]     older_reg [AS];
    logic [AS-1:0]     due_reg, due_next;
    logic [AS-1:0]     le_reg;
    logic [TIME_W-1:0] best_reg;
    state_t            state_reg, state_next;

    logic              ov_reg;
    logic [1:0]        ok_reg;
    logic [3:0]        os_reg;
    logic              oa_reg, ol_reg;
    logic              out_free;

    logic              id_ok;
    logic [SW-1:0]     id_s;
    cand_t             lvl0 [16];
    cand_t             lvl1 [8];
    cand_t             lvl2 [4];
    cand_t             lvl3 [2];
    cand_t             min_c;
    logic [AS-1:0]     ties_c;
    logic [SW-1:0]     pick_c;
    logic              pick_have;
    logic [AS-1:0]     pick_bit, due_left;
    logic              imm_go, scan_go, emit_go, last_emit;

    function automatic cand_t min_pair(input cand_t a, input cand_t b);
        if (a.have && (!b.have || a.val <= b.val))
            return a;
        return b;
    endfunction

    assign out_free = !ov_reg || out_ch.ready;
    assign id_ok    = ({28'd0, cmd.timer_id} < 32'(NUM_TIMERS));
    assign id_s     = SW'(cmd.timer_id);

    // minimum expiry among due slots (tree over at most 16 entries)
    always_comb
    begin
        for (int k = 0; k < 16; k++)
            lvl0[k] = '0;
        for (int k = 0; k < AS; k++)
        begin
            lvl0[k].have = due_reg[k];
            lvl0[k].val  = exp_reg[k];
        end
        for (int k = 0; k < 8; k++)
            lvl1[k] = min_pair(lvl0[2*k], lvl0[2*k+1]);
        for (int k = 0; k < 4; k++)
            lvl2[k] = min_pair(lvl1[2*k], lvl1[2*k+1]);
        for (int k = 0; k < 2; k++)
            lvl3[k] = min_pair(lvl2[2*k], lvl2[2*k+1]);
        min_c = min_pair(lvl3[0], lvl3[1]);
    end

    // winner among due slots with the minimum expiry, oldest start first
    always_comb
    begin
        ties_c    = '0;
        pick_c    = '0;
        pick_have = 1'b0;
        for (int k = 0; k < AS; k++)
            ties_c[k] = due_reg[k] && (exp_reg[k] == best_reg);
        for (int k = 0; k < AS; k++)
        begin
            if (!pick_have && ties_c[k] && ((older_reg[k] & ties_c) == '0))
            begin
                pick_c    = SW'(k);
                pick_have = 1'b1;
            end
        end
    end

    assign pick_bit  = AS'(1) << pick_c;
    assign due_left  = due_reg & ~pick_bit;
    assign last_emit = (due_left == '0);

    assign imm_go  = (state_reg == ST_IDLE) && cmd_valid && out_free
                     && (cmd.action != ACT_TICK);
    assign scan_go = (state_reg == ST_IDLE) && cmd_valid && (cmd.action == ACT_TICK);
    assign emit_go = (state_reg == ST_EMIT) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (scan_go) state_next = ST_SCAN;
            ST_SCAN: state_next = ST_PICK;
            ST_PICK: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = last_emit ? ST_IDLE : ST_PICK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = imm_go || (emit_go && last_emit);
        due_next = due_reg;
        if (state_reg == ST_SCAN)
            due_next = armed_reg & le_reg;
        else if (emit_go)
            due_next = due_left;
    end

    always_ff @(posedge clk)
    begin
        if (scan_go)
            for (int k = 0; k < AS; k++)
                le_reg[k] <= (exp_reg[k] <= cmd.tval);
        if (state_reg == ST_PICK)
            best_reg <= min_c.val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            armed_reg <= '0;
            due_reg   <= '0;
            ov_reg    <= 1'b0;
            ok_reg    <= KIND_ACK;
            os_reg    <= 4'd0;
            oa_reg    <= 1'b0;
            ol_reg    <= 1'b0;
            for (int k = 0; k < AS; k++)
            begin
                exp_reg[k]   <= '0;
                older_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            due_reg   <= due_next;
            if (imm_go || emit_go)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;

            if (imm_go)
            begin
                os_reg <= cmd.timer_id;
                ol_reg <= 1'b1;
                case (cmd.action)
                    ACT_START:
                    begin
                        ok_reg <= KIND_ACK;
                        oa_reg <= id_ok;
                        if (id_ok)
                        begin
                            exp_reg[id_s]   <= cmd.tval;
                            older_reg[id_s] <= armed_reg & ~(AS'(1) << id_s);
                            armed_reg[id_s] <= 1'b1;
                            for (int k = 0; k < AS; k++)
                                if (k != int'(id_s))
                                    older_reg[k][id_s] <= 1'b0;
                        end
                    end
                    ACT_CANCEL:
                    begin
                        ok_reg <= KIND_ACK;
                        oa_reg <= 1'b0;
                        if (id_ok)
                        begin
                            armed_reg[id_s] <= 1'b0;
                            older_reg[id_s] <= '0;
                            for (int k = 0; k < AS; k++)
                                if (k != int'(id_s))
                                    older_reg[k][id_s] <= 1'b0;
                        end
                    end
                    default:
                    begin
                        ok_reg <= KIND_STAT;
                        oa_reg <= id_ok && armed_reg[id_s];
                    end
                endcase
            end

            if (emit_go)
            begin
                oa_reg <= 1'b0;
                if (due_reg == '0)
                begin
                    ok_reg <= KIND_NONE;
                    os_reg <= 4'd0;
                    ol_reg <= 1'b1;
                end
                else
                begin
                    ok_reg            <= KIND_FIRED;
                    os_reg            <= 4'(pick_c);
                    ol_reg            <= last_emit;
                    armed_reg[pick_c] <= 1'b0;
                    older_reg[pick_c] <= '0;
                    for (int k = 0; k < AS; k++)
                        if (k != int'(pick_c))
                            older_reg[k][pick_c] <= 1'b0;
                end
            end
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.kind      = ok_reg;
    assign out_ch.slot_id   = os_reg;
    assign out_ch.is_active = oa_reg;
    assign out_ch.last      = ol_reg;
endmodule
`default_nettype wire

// ===== src/ordered_timer_expiry_queue.sv =====
// ----------------------------------------------------------------------------
// ordered_timer_expiry_queue: timer slots with ordered expiry
// Front queues commands, back executes them and streams fired slots.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | action, timer_id, expiry_ns, now_ns
//  out_ch  | out | kind, slot_id, is_active, last
//
//  Every word is registered in the command queue before the back end sees it.
//  Start, cancel and query: executed from ST_IDLE when the output register is free; result registered.
//  Tick: compare step (ST_IDLE), due-load step (ST_SCAN), then a min-search step
//  (ST_PICK) and an emit step (ST_EMIT) per fired slot, or once for an empty tick.
//  A full output register stalls the emit step and start/cancel/query; the two-word
//  queue lets input run ahead meanwhile. Reset clears all slots at once; no clearing pass.
`default_nettype none
module ordered_timer_expiry_queue #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  wire       clk,
    input  wire       rst_n,
    otq_in_if.sink    in_ch,
    otq_out_if.source out_ch
);
    import otq_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_pop;

    otq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
    );

    otq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// ===== src/otq_checker.sv =====
// ----------------------------------------------------------------------------
// otq_checker: port-level checks of the timer queue
// Output handshake and result coding rules.
// ----------------------------------------------------------------------------
`default_nettype none
module otq_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire [1:0] out_kind,
    input wire [3:0] out_slot_id,
    input wire       out_is_active,
    input wire       out_last
);
    import otq_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("output word dropped under stall");

    a_fired_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_FIRED |-> !out_is_active)
        else $error("fired slot reported active");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_ACK || out_kind == KIND_STAT
                      || out_kind == KIND_NONE) |-> out_last)
        else $error("single result without last");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_NONE |-> out_slot_id == 4'd0 && !out_is_active)
        else $error("empty tick result not zero");
endmodule

bind ordered_timer_expiry_queue otq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.kind), .out_slot_id(out_ch.slot_id),
    .out_is_active(out_ch.is_active), .out_last(out_ch.last)
);
`default_nettype wire
